>>> hw/rtl/hctd_pkg.sv
// Shared types, codes and helpers for the HTTP chunked transfer decoder.
// Used by hctd_core and http_chunked_transfer_decoder; no dependencies.
package hctd_pkg;

  localparam int DEFAULT_SIZE_BITS = 32;
  localparam int DIGITS_W = 4;
  localparam logic [DIGITS_W-1:0] MAX_DIGITS_RESET = 4'd8;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_TRAILER = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_SIZE  = 2'd1,
    ERR_END_SIZE  = 2'd2,
    ERR_END_CHUNK = 2'd3
  } err_t;

  typedef enum logic [6:0] {
    PH_SIZE     = 7'b0000001,
    PH_EXT      = 7'b0000010,
    PH_DATA     = 7'b0000100,
    PH_DATA_END = 7'b0001000,
    PH_TRAILER  = 7'b0010000,
    PH_DONE     = 7'b0100000,
    PH_ERROR    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      out_kind;
    err_t       error_code;
  } out_item_t;

  typedef struct packed {
    logic ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> hw/rtl/hctd_core.sv
// Decoder state and the per-byte update: size line parse, chunk data count,
// trailer pass-through. Depends on hctd_pkg.
module hctd_core #(
  parameter int SIZE_BITS = hctd_pkg::DEFAULT_SIZE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step_en,
  input  hctd_pkg::in_item_t                 item,
  input  logic [hctd_pkg::DIGITS_W-1:0]      max_digits,
  output logic                               res_valid,
  output hctd_pkg::out_item_t                res
);
  import hctd_pkg::*;

  localparam int MAX_DIGITS = SIZE_BITS / 4;

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  bytes_left, bytes_left_next;
  logic [DIGITS_W-1:0]   digit_count, digit_count_next;
  logic                  trailer_line_empty, trailer_line_empty_next;
  logic                  emit;
  out_item_t             emit_item;
  hex_digit_t            hd;
  logic [7:0]            c;
  logic                  ended;
  logic                  too_many;
  logic [SIZE_BITS-1:0]  bytes_dec;

  assign c = item.in_byte;
  assign ended = item.stream_end;
  assign hd = hex_value(c);
  assign too_many = (digit_count >= max_digits) ||
                    ({1'b0, digit_count} >= (DIGITS_W+1)'(MAX_DIGITS));
  assign bytes_dec = bytes_left - SIZE_BITS'(1);

  always_comb begin
    phase_next = phase;
    bytes_left_next = bytes_left;
    digit_count_next = digit_count;
    trailer_line_empty_next = trailer_line_empty;
    emit = 1'b0;
    emit_item = '{out_byte: 8'd0, out_kind: KIND_ERROR, error_code: ERR_NONE};
    unique case (phase)
      PH_SIZE, PH_EXT, PH_DATA_END: begin
        if (ended) begin
          phase_next = PH_ERROR;
          emit = 1'b1;
          emit_item.error_code = ERR_END_SIZE;
        end else if (c == CR_BYTE) begin
          phase_next = phase;
        end else if (phase == PH_DATA_END) begin
          if (c == LF_BYTE) phase_next = PH_SIZE;
        end else if (c == LF_BYTE) begin
          if (digit_count == '0) begin
            phase_next = PH_ERROR;
            emit = 1'b1;
            emit_item.error_code = ERR_BAD_SIZE;
          end else begin
            digit_count_next = '0;
            if (bytes_left == '0) begin
              trailer_line_empty_next = 1'b1;
              phase_next = PH_TRAILER;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end else if (phase == PH_EXT) begin
          phase_next = phase;
        end else if (c == SPACE_BYTE) begin
          phase_next = PH_EXT;
        end else if (!hd.ok || too_many) begin
          phase_next = PH_ERROR;
          emit = 1'b1;
          emit_item.error_code = ERR_BAD_SIZE;
        end else begin
          digit_count_next = DIGITS_W'(digit_count + 1'b1);
          bytes_left_next = {bytes_left[SIZE_BITS-5:0], hd.value};
        end
      end
      PH_DATA: begin
        emit = 1'b1;
        if (ended) begin
          phase_next = PH_ERROR;
          emit_item.error_code = ERR_END_CHUNK;
        end else begin
          bytes_left_next = bytes_dec;
          if (bytes_dec == '0) phase_next = PH_DATA_END;
          emit_item.out_byte = c;
          emit_item.out_kind = KIND_PAYLOAD;
        end
      end
      PH_TRAILER: begin
        if (ended || (c == LF_BYTE && trailer_line_empty)) begin
          phase_next = PH_DONE;
          emit = 1'b1;
          emit_item.out_kind = KIND_DONE;
        end else if (c != CR_BYTE) begin
          emit = 1'b1;
          emit_item.out_byte = c;
          emit_item.out_kind = KIND_TRAILER;
          trailer_line_empty_next = (c == LF_BYTE);
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  assign res_valid = step_en && emit;
  assign res = emit_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SIZE;
      bytes_left <= '0;
      digit_count <= '0;
      trailer_line_empty <= 1'b1;
    end else if (step_en) begin
      phase <= phase_next;
      bytes_left <= bytes_left_next;
      digit_count <= digit_count_next;
      trailer_line_empty <= trailer_line_empty_next;
    end
  end

  a_digits_bounded: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, digit_count} <= (DIGITS_W+1)'(MAX_DIGITS)))
    else $error("digit count beyond size width");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != '0))
    else $error("data phase with no bytes left");

  a_hold_final: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE || phase == PH_ERROR) |=> $stable(phase))
    else $error("left terminal phase");

endmodule

>>> hw/rtl/http_chunked_transfer_decoder.sv
// HTTP/1.1 chunked body decoder: one raw byte in, at most one payload, trailer,
// complete or error item out. Top level; depends on hctd_pkg and hctd_core.
//
// Takes one byte item per cycle and sustains one item per cycle while out_stall
// is low: each byte passes an input register, a state update in hctd_core,
// and an output register that holds the item until it is taken. Bytes
// that produce no result (CR, size digits, extensions, line endings) are
// absorbed without an output item. in_stall rises only when the output
// register is full and stalled. After the complete item or an error item
// nothing more is produced until rst. cfg_data (max size digits, reset 8) is
// always accepted and should only be written while the decoder is idle.
module http_chunked_transfer_decoder #(
  parameter int SIZE_BITS = hctd_pkg::DEFAULT_SIZE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hctd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hctd_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hctd_pkg::DIGITS_W-1:0]  cfg_data
);
  import hctd_pkg::*;

  logic                 s1_valid;
  in_item_t             s1_item;
  logic                 advance;
  logic                 accept;
  logic                 res_valid;
  out_item_t            res;
  logic [DIGITS_W-1:0]  max_digits;

  assign advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_digits <= MAX_DIGITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_digits <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_item <= in_data;
  end

  hctd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .item       (s1_item),
    .max_digits (max_digits),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) out_data <= res;
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked output");

  a_new_out_from_core: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && res_valid))
    else $error("output item without a core result");

  a_err_code_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.out_kind == KIND_ERROR) == (out_data.error_code != ERR_NONE)))
    else $error("error code inconsistent with kind");

  a_byte_zero_for_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.out_kind == KIND_DONE || out_data.out_kind == KIND_ERROR))
      |-> (out_data.out_byte == 8'd0))
    else $error("status item carries a byte");

endmodule

>>> test/tb.sv
// Testbench for http_chunked_transfer_decoder: sends chunked bodies byte by byte
// with random input gaps and output stalls and checks each item against a
// behavioral decoder in this file. Depends on hctd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb;
  import hctd_pkg::*;

  localparam int SZ = 32;
  localparam int SZ_DIGITS = SZ / 4;

  typedef enum int {
    ENDS_BLANK_LINE,
    ENDS_TRAILER_CUT,
    ENDS_BAD_CHAR,
    ENDS_LONG_SIZE,
    ENDS_EMPTY_SIZE,
    ENDS_CUT_IN_SIZE,
    ENDS_CUT_IN_EXT,
    ENDS_CUT_IN_DATA,
    ENDS_CUT_AT_CRLF,
    ENDS_ZERO_LIMIT
  } ending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DIGITS_W-1:0] cfg_data = '0;

  bit failed = 1'b0;
  bit burst = 1'b0;
  int n_sent = 0;
  int stall_left = 0;
  int digit_limit = MAX_DIGITS_RESET;

  phase_t m_phase;
  logic [SZ-1:0] m_remain;
  logic [3:0] m_ndig;
  logic m_trl_empty;
  logic [3:0] m_max_dig;
  out_item_t decoded_q[$];

  http_chunked_transfer_decoder #(.SIZE_BITS(SZ)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  function automatic void model_reset();
    m_phase = PH_SIZE;
    m_remain = '0;
    m_ndig = '0;
    m_trl_empty = 1'b1;
    m_max_dig = MAX_DIGITS_RESET;
  endfunction

  function automatic bit model_fail(input err_t code, output out_item_t r);
    m_phase = PH_ERROR;
    r = '{out_byte: 8'h00, out_kind: KIND_ERROR, error_code: code};
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input in_item_t it, output out_item_t r);
    int v;
    r = '{out_byte: 8'h00, out_kind: KIND_PAYLOAD, error_code: ERR_NONE};
    case (m_phase)
      PH_SIZE, PH_EXT, PH_DATA_END: begin
        if (it.stream_end) return model_fail(ERR_END_SIZE, r);
        if (it.in_byte == CR_BYTE) return 1'b0;
        if (m_phase == PH_DATA_END) begin
          if (it.in_byte == LF_BYTE) m_phase = PH_SIZE;
          return 1'b0;
        end
        if (it.in_byte == LF_BYTE) begin
          if (m_ndig == 0) return model_fail(ERR_BAD_SIZE, r);
          m_ndig = '0;
          if (m_remain == 0) begin
            m_trl_empty = 1'b1;
            m_phase = PH_TRAILER;
          end else begin
            m_phase = PH_DATA;
          end
          return 1'b0;
        end
        if (m_phase == PH_EXT) return 1'b0;
        if (it.in_byte == SPACE_BYTE) begin
          m_phase = PH_EXT;
          return 1'b0;
        end
        v = nibble_of(it.in_byte);
        if (v < 0 || m_ndig >= m_max_dig || m_ndig >= SZ_DIGITS)
          return model_fail(ERR_BAD_SIZE, r);
        m_ndig = m_ndig + 1'b1;
        m_remain = {m_remain[SZ-5:0], 4'(v)};
        return 1'b0;
      end
      PH_DATA: begin
        if (it.stream_end) return model_fail(ERR_END_CHUNK, r);
        m_remain = m_remain - 1'b1;
        if (m_remain == 0) m_phase = PH_DATA_END;
        r.out_byte = it.in_byte;
        return 1'b1;
      end
      PH_TRAILER: begin
        if (it.stream_end || (it.in_byte == LF_BYTE && m_trl_empty)) begin
          m_phase = PH_DONE;
          r.out_kind = KIND_DONE;
          return 1'b1;
        end
        if (it.in_byte == CR_BYTE) return 1'b0;
        m_trl_empty = (it.in_byte == LF_BYTE);
        r.out_byte = it.in_byte;
        r.out_kind = KIND_TRAILER;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t r;
    if (rst) begin
      model_reset();
    end else begin
      if (cfg_valid && cfg_ready) m_max_dig = cfg_data;
      if (in_valid && !in_stall) begin
        if (decode_byte(in_data, r)) decoded_q.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual byte %0h kind %0h err %0h",
                   $time, out_data.out_byte, out_data.out_kind, out_data.error_code);
          failed = 1'b1;
        end else begin
          r = decoded_q.pop_front();
          check_field("out_byte", r.out_byte, out_data.out_byte);
          check_field("out_kind", 8'(r.out_kind), 8'(out_data.out_kind));
          check_field("error_code", 8'(r.error_code), 8'(out_data.error_code));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      stall_left = burst ? 0 : $urandom_range(0, 18);
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  task automatic put_item(input logic [7:0] b, input logic e);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, stream_end: e};
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic put_end();
    put_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_digits(input logic [3:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    digit_limit = int'(v);
  endtask

  function automatic int eff_limit();
    return (digit_limit > SZ_DIGITS) ? SZ_DIGITS : digit_limit;
  endfunction

  function automatic int rand_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(13, (eff_limit() == 1) ? 15 : 64);
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 10) return 8'h30 + {4'h0, nib};
    return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
  endfunction

  function automatic logic [7:0] text_byte(input bit allow_cr);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == LF_BYTE || (!allow_cr && b == CR_BYTE));
    return b;
  endfunction

  function automatic logic [7:0] bad_size_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (nibble_of(b) >= 0 || b == SPACE_BYTE || b == CR_BYTE || b == LF_BYTE);
    return b;
  endfunction

  // hex size with random case, leading zeros and stray CRs
  task automatic put_size(input logic [31:0] value, input int lim);
    int nd;
    int total;
    int i;
    logic [3:0] nib;
    nd = 1;
    while (nd < 8 && (value >> (4 * nd)) != 0) nd++;
    total = $urandom_range(nd, (lim > nd) ? lim : nd);
    for (i = total - 1; i >= 0; i--) begin
      nib = 4'(value >> (4 * i));
      put_item(hex_char(nib, 1'($urandom_range(0, 1))), 1'b0);
      if ($urandom_range(0, 7) == 0) put_item(CR_BYTE, 1'b0);
    end
  endtask

  task automatic put_ext();
    put_item(SPACE_BYTE, 1'b0);
    repeat ($urandom_range(0, 6)) put_item(text_byte(1'b1), 1'b0);
  endtask

  task automatic put_line_end();
    if ($urandom_range(0, 1)) put_item(CR_BYTE, 1'b0);
    put_item(LF_BYTE, 1'b0);
  endtask

  task automatic put_chunk(input int size);
    put_size(size, eff_limit());
    if ($urandom_range(0, 3) == 0) put_ext();
    put_line_end();
    repeat (size) put_item(8'($urandom_range(0, 255)), 1'b0);
    if ($urandom_range(0, 9) == 0) put_item(text_byte(1'b1), 1'b0);
    put_line_end();
  endtask

  task automatic put_trailer_line();
    put_item(text_byte(1'b0), 1'b0);
    repeat ($urandom_range(0, 7)) put_item(text_byte(1'b1), 1'b0);
  endtask

  task automatic test_line_rules();
    put_text("1");
    put_item(CR_BYTE, 1'b0);
    put_text("\n");
    put_item(8'h00, 1'b0);
    put_item(CR_BYTE, 1'b0);
    put_text("\n");
    put_text("2 ;e");
    put_item(CR_BYTE, 1'b0);
    put_item(CR_BYTE, 1'b0);
    put_text("\n");
    put_item(8'hFF, 1'b0);
    put_item(LF_BYTE, 1'b0);
    put_text("x\n");
    put_text("0001\n");
    put_item(CR_BYTE, 1'b0);
    put_text("\n");
  endtask

  task automatic test_digit_limit();
    set_max_digits(4'd1);
    put_text("f\n");
    repeat (15) put_item(8'($urandom_range(0, 255)), 1'b0);
    put_text("\n");
    set_max_digits(4'd15);
    put_text("00000002\n");
    repeat (2) put_item(8'($urandom_range(0, 255)), 1'b0);
    put_text("\n");
    set_max_digits(4'd8);
    put_text("0000000A\n");
    repeat (10) put_item(8'($urandom_range(0, 255)), 1'b0);
    put_text("\n");
  endtask

  task automatic test_random_body();
    while (n_sent < 720) begin
      if ($urandom_range(0, 4) == 0) burst = ~burst;
      if ($urandom_range(0, 39) == 0) set_max_digits(4'($urandom_range(1, 15)));
      put_chunk(rand_size());
    end
    burst = 1'b0;
  endtask

  // one way of ending the message, then bytes that must be ignored
  task automatic test_message_end();
    ending_t how;
    logic [31:0] big;
    int n;
    how = ending_t'($urandom_range(0, 9));
    case (how)
      ENDS_BLANK_LINE, ENDS_TRAILER_CUT: begin
        put_size(0, eff_limit());
        if ($urandom_range(0, 1)) put_ext();
        put_line_end();
        repeat ($urandom_range(1, 3)) begin
          put_trailer_line();
          put_line_end();
        end
        if (how == ENDS_BLANK_LINE) begin
          put_line_end();
        end else begin
          if ($urandom_range(0, 1)) put_trailer_line();
          put_end();
        end
      end
      ENDS_BAD_CHAR: begin
        if ($urandom_range(0, 1)) put_size(rand_size(), eff_limit());
        put_item(bad_size_byte(), 1'b0);
      end
      ENDS_LONG_SIZE: begin
        repeat (eff_limit() + 1)
          put_item(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
      end
      ENDS_EMPTY_SIZE: begin
        if ($urandom_range(0, 1)) put_ext();
        put_line_end();
      end
      ENDS_CUT_IN_SIZE: begin
        if ($urandom_range(0, 1)) put_size(rand_size(), eff_limit());
        put_end();
      end
      ENDS_CUT_IN_EXT: begin
        put_size(rand_size(), eff_limit());
        put_ext();
        put_end();
      end
      ENDS_CUT_IN_DATA: begin
        if (eff_limit() == SZ_DIGITS && $urandom_range(0, 1)) big = $urandom() | 32'd1;
        else big = rand_size();
        put_size(big, eff_limit());
        put_line_end();
        n = $urandom_range(0, (big > 21) ? 20 : big - 1);
        repeat (n) put_item(8'($urandom_range(0, 255)), 1'b0);
        put_end();
      end
      ENDS_CUT_AT_CRLF: begin
        n = rand_size();
        put_size(n, eff_limit());
        put_line_end();
        repeat (n) put_item(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 1)) put_item(CR_BYTE, 1'b0);
        put_end();
      end
      default: begin
        set_max_digits(4'd0);
        put_item(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
      end
    endcase
    repeat (12) put_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_line_rules();
    test_digit_limit();
    test_random_body();
    test_message_end();
    drain();
    repeat (10) @(posedge clk);
    if (failed || decoded_q.size() != 0) begin
      $display("simulation failed");
    end else begin
      $display("simulation ok");
    end
    $finish;
  end

endmodule
